### rtl/aes_pkg.sv
package aes_pkg;

    localparam int ROUND_COUNT = 10;
    localparam int KEY_ROWS    = ROUND_COUNT + 1;
    localparam int RND_W       = $clog2(KEY_ROWS);
    localparam int PADDR_W     = 4;

    // register word indices, matched against paddr[3:2]; bits [1:0] are not decoded
    localparam logic [PADDR_W-3:0] REG_KEY_HIGH = 2'b00;
    localparam logic [PADDR_W-3:0] REG_KEY_LOW  = 2'b10;

    typedef logic [RND_W-1:0] t_rnd;
    typedef logic [127:0]     t_block;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXPAND,
        ST_ROUND
    } t_state;

    typedef struct packed {
        logic load;      // plaintext beat xor round key 0 into state
        logic round;     // one full round into state
        logic out_load;  // final round into output register
        logic key_we;    // key schedule step, write one round key row
        logic key_first; // schedule starts from the key registers
        t_rnd key_addr;
        t_rnd rd_addr;
    } t_dp_cmd;

    localparam logic [7:0] SBOX [256] = '{
        8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
        8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
        8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
        8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
        8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
        8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
        8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
        8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
        8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
        8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
        8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
        8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
        8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
        8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
        8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
        8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
        8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
        8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
        8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
        8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
        8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
        8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
        8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
        8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
        8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
        8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
        8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
        8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
        8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
        8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
        8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
        8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
    };

    // round constants by schedule step, unused tail is zero
    localparam logic [7:0] RCON [2**RND_W] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80,
        8'h1b, 8'h36, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
    };

    // byte 0 of the block sits in bits 127:120
    function automatic t_block sub_shift(input t_block s);
        t_block t;
        int     src;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                src = r + 4 * ((c + r) & 3);
                t[127 - 8 * (r + 4 * c) -: 8] = SBOX[s[127 - 8 * src -: 8]];
            end
        end
        return t;
    endfunction

    function automatic logic [7:0] xtime(input logic [7:0] b);
        return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block     t;
        logic [7:0] a0, a1, a2, a3, all;
        t = '0;
        for (int c = 0; c < 4; c++) begin
            a0  = s[127 - 32 * c -: 8];
            a1  = s[119 - 32 * c -: 8];
            a2  = s[111 - 32 * c -: 8];
            a3  = s[103 - 32 * c -: 8];
            all = a0 ^ a1 ^ a2 ^ a3;
            t[127 - 32 * c -: 8] = a0 ^ all ^ xtime(a0 ^ a1);
            t[119 - 32 * c -: 8] = a1 ^ all ^ xtime(a1 ^ a2);
            t[111 - 32 * c -: 8] = a2 ^ all ^ xtime(a2 ^ a3);
            t[103 - 32 * c -: 8] = a3 ^ all ^ xtime(a3 ^ a0);
        end
        return t;
    endfunction

    function automatic t_block next_round_key(input t_block k, input logic [7:0] rc);
        logic [31:0] w0, w1, w2, w3, t;
        w0 = k[127:96];
        w1 = k[95:64];
        w2 = k[63:32];
        w3 = k[31:0];
        t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        t  = t ^ {rc, 24'h0};
        w0 = w0 ^ t;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

### rtl/aes128_block_encrypt_core.sv
// a result beat is registered after the initial key add and 10 rounds, one round per cycle
// through a single round unit; the final round waits while the output register is full, and no
// new input beat is taken until the block is done; a key register write runs the key schedule,
// one round key row per cycle, during which no input beat is taken
// reset is synchronous, active low; clears control and the key registers, round key store is
// loaded only by a key write
module aes128_block_encrypt_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [aes_pkg::PADDR_W-1:0]  paddr,
    input  logic [63:0]                  pwdata,
    output logic [63:0]                  prdata,
    output logic                         pready,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [127:0]                 s_axis_tdata,  // plain_low in [127:64], plain_high in [63:0]
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [127:0]                 m_axis_tdata   // cipher_low in [127:64], cipher_high in [63:0]
);
    import aes_pkg::*;

    logic [63:0] r_key_high;
    logic [63:0] r_key_low;
    logic        w_wr;
    logic        w_wr_high;
    logic        w_wr_low;
    t_dp_cmd     w_cmd;
    t_block      w_cipher;

    assign pready    = 1'b1;
    assign w_wr      = psel && penable && pwrite && pready;
    assign w_wr_high = w_wr && (paddr[PADDR_W-1:2] == REG_KEY_HIGH);
    assign w_wr_low  = w_wr && (paddr[PADDR_W-1:2] == REG_KEY_LOW);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else begin
            if (w_wr_high) begin
                r_key_high <= pwdata;
            end
            if (w_wr_low) begin
                r_key_low <= pwdata;
            end
        end
    end

    always_comb begin
        unique case (paddr[PADDR_W-1:2])
            REG_KEY_HIGH: prdata = r_key_high;
            REG_KEY_LOW:  prdata = r_key_low;
            default:      prdata = '0;
        endcase
    end

    aes_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_wr  (w_wr_high || w_wr_low),
        .i_s_valid (s_axis_tvalid),
        .i_m_ready (m_axis_tready),
        .o_s_ready (s_axis_tready),
        .o_m_valid (m_axis_tvalid),
        .o_cmd     (w_cmd)
    );

    // schedule reads the key registers in the cycle after the write, once the new value has landed
    aes_dp u_dp (
        .i_clk    (i_clk),
        .i_cmd    (w_cmd),
        .i_key    ({r_key_high, r_key_low}),
        .i_plain  ({s_axis_tdata[63:0], s_axis_tdata[127:64]}),
        .o_cipher (w_cipher)
    );

    assign m_axis_tdata = {w_cipher[63:0], w_cipher[127:64]};

endmodule

### rtl/aes_dp.sv
module aes_dp (
    input  logic             i_clk,
    input  aes_pkg::t_dp_cmd i_cmd,
    input  aes_pkg::t_block  i_key,
    input  aes_pkg::t_block  i_plain,
    output aes_pkg::t_block  o_cipher
);
    import aes_pkg::*;

    t_block r_mem [KEY_ROWS];
    t_block r_rk;
    t_block r_state;
    t_block r_kw;
    t_block r_cipher;

    t_block w_kw_src;
    t_block w_sub;
    t_block w_mix;

    assign w_kw_src = i_cmd.key_first ? i_key : r_kw;
    assign w_sub    = sub_shift(r_state);
    assign w_mix    = mix_columns(w_sub);

    // round key store, read data registered, address is prefetched by the controller
    always_ff @(posedge i_clk) begin
        if (i_cmd.key_we) begin
            r_mem[i_cmd.key_addr] <= w_kw_src;
        end
        r_rk <= r_mem[i_cmd.rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.key_we) begin
            r_kw <= next_round_key(w_kw_src, RCON[i_cmd.key_addr]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_state <= i_plain ^ r_rk;
        end else if (i_cmd.round) begin
            r_state <= w_mix ^ r_rk;
        end
    end

    // final round skips mix columns
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_cipher <= w_sub ^ r_rk;
        end
    end

    assign o_cipher = r_cipher;

endmodule

### rtl/aes_ctrl.sv
module aes_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr,
    input  logic             i_s_valid,
    input  logic             i_m_ready,
    output logic             o_s_ready,
    output logic             o_m_valid,
    output aes_pkg::t_dp_cmd o_cmd
);
    import aes_pkg::*;

    localparam t_rnd LAST_RND = t_rnd'(ROUND_COUNT);
    localparam t_rnd ONE_RND  = t_rnd'(1);

    t_state r_state, n_state;
    t_rnd   r_rnd, n_rnd;
    logic   r_m_valid, n_m_valid;
    logic   w_accept;
    logic   w_out_free;

    // a key write takes the cycle, no beat may be taken alongside it
    assign o_s_ready  = (r_state == ST_IDLE) && !i_cfg_wr;
    assign w_accept   = i_s_valid && o_s_ready;
    assign w_out_free = !r_m_valid || i_m_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_rnd     <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_rnd     <= n_rnd;
            r_m_valid <= n_m_valid;
        end
    end

    always_comb begin
        n_state = r_state;
        n_rnd   = r_rnd;
        o_cmd   = '0;
        priority if (i_cfg_wr) begin
            // any key write restarts the schedule from row 0
            n_state = ST_EXPAND;
            n_rnd   = '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        o_cmd.load    = 1'b1;
                        o_cmd.rd_addr = ONE_RND;
                        n_state       = ST_ROUND;
                        n_rnd         = ONE_RND;
                    end
                end
                ST_EXPAND: begin
                    o_cmd.key_we    = 1'b1;
                    o_cmd.key_first = (r_rnd == '0);
                    o_cmd.key_addr  = r_rnd;
                    if (r_rnd == LAST_RND) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_rnd = r_rnd + ONE_RND;
                    end
                end
                ST_ROUND: begin
                    if (r_rnd == LAST_RND) begin
                        // hold the last key until the output register frees up
                        o_cmd.rd_addr = LAST_RND;
                        if (w_out_free) begin
                            o_cmd.out_load = 1'b1;
                            o_cmd.rd_addr  = '0;
                            n_state        = ST_IDLE;
                        end
                    end else begin
                        o_cmd.round   = 1'b1;
                        o_cmd.rd_addr = r_rnd + ONE_RND;
                        n_rnd         = r_rnd + ONE_RND;
                    end
                end
                default: begin
                    n_state = ST_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        if (o_cmd.out_load) begin
            n_m_valid = 1'b1;
        end else if (i_m_ready) begin
            n_m_valid = 1'b0;
        end else begin
            n_m_valid = r_m_valid;
        end
    end

    assign o_m_valid = r_m_valid;

    a_rnd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rnd <= LAST_RND)
        else $error("round counter out of range");

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && !i_cfg_wr |=> r_state == ST_ROUND && r_rnd == ONE_RND)
        else $error("accepted beat did not start the rounds");

    a_result_after_rounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_m_valid) |-> $past(r_state == ST_ROUND && r_rnd == LAST_RND))
        else $error("result shown without finishing the rounds");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> w_out_free)
        else $error("pending result overwritten");

    a_expand_ends_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_EXPAND && r_rnd == LAST_RND && !i_cfg_wr |=> r_state == ST_IDLE)
        else $error("key schedule did not return to idle");

endmodule

### bench/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import aes_pkg::*;

    localparam logic [PADDR_W-1:0] ADDR_KEY_HIGH = {REG_KEY_HIGH, 2'b00};
    localparam logic [PADDR_W-1:0] ADDR_KEY_LOW  = {REG_KEY_LOW, 2'b00};
    // byte addresses with no register behind them
    localparam logic [PADDR_W-1:0] ADDR_HOLE_A   = 4'h4;
    localparam logic [PADDR_W-1:0] ADDR_HOLE_B   = 4'hc;

    localparam int SCHEDULE_CYCLES = KEY_ROWS + 4;
    localparam int DRAIN_CYCLES    = KEY_ROWS + 4;
    localparam int GAP_MAX         = 7;
    localparam int RANDOM_BLOCKS   = 1600;
    localparam int STALL_CYCLES    = 300;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [63:0]         pwdata;
    logic [63:0]         prdata;
    logic                pready;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [127:0]        s_axis_tdata;   // plain_low in [127:64], plain_high in [63:0]
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [127:0]        m_axis_tdata;   // cipher_low in [127:64], cipher_high in [63:0]

    aes128_block_encrypt_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #4 i_clk = ~i_clk;

    // shadow of the key registers and the round keys they expand to
    logic [63:0]  key_high_q = '0;
    logic [63:0]  key_low_q  = '0;
    logic [127:0] round_key [KEY_ROWS];
    logic [7:0]   sub_table [256];

    logic [127:0] cipher_expected [$];
    logic [127:0] cipher_want;

    int mismatch_count  = 0;
    int blocks_sent     = 0;
    int results_checked = 0;
    int key_loads       = 0;
    int src_gap_max     = GAP_MAX;
    int sink_gap_max    = GAP_MAX;
    int sink_hold       = 0;
    int longest_hold    = 0;

    function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] p;
        logic [7:0] x;
        p = '0;
        x = a;
        for (int i = 0; i < 8; i++) begin
            if (b[i]) p ^= x;
            x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
        end
        return p;
    endfunction

    // s-box from the field inverse and the affine map
    function automatic void build_sub_table();
        logic [7:0] inv;
        for (int x = 0; x < 256; x++) begin
            inv = 8'h00;
            if (x != 0) begin
                inv = 8'h01;
                for (int k = 0; k < 254; k++) inv = gf_mul(inv, 8'(x));
            end
            sub_table[x] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]}
                         ^ {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ 8'h63;
        end
    endfunction

    function automatic void schedule_keys();
        logic [31:0] w [4*KEY_ROWS];
        logic [31:0] t;
        logic [7:0]  rc;
        {w[0], w[1], w[2], w[3]} = {key_high_q, key_low_q};
        rc = 8'h01;
        for (int i = 4; i < 4 * KEY_ROWS; i++) begin
            t = w[i-1];
            if (i % 4 == 0) begin
                t = {sub_table[t[23:16]], sub_table[t[15:8]], sub_table[t[7:0]],
                     sub_table[t[31:24]]} ^ {rc, 24'h0};
                rc = gf_mul(rc, 8'h02);
            end
            w[i] = w[i-4] ^ t;
        end
        for (int r = 0; r < KEY_ROWS; r++)
            round_key[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
    endfunction

    // state byte r + 4c is row r of column c, byte 0 in the top bits
    function automatic logic [127:0] encrypt_block(input logic [127:0] plain);
        logic [7:0]   st [16];
        logic [7:0]   sh [16];
        logic [7:0]   a0, a1, a2, a3;
        logic [127:0] res;
        for (int i = 0; i < 16; i++)
            st[i] = plain[127-8*i -: 8] ^ round_key[0][127-8*i -: 8];
        for (int r = 1; r <= ROUND_COUNT; r++) begin
            for (int c = 0; c < 4; c++)
                for (int row = 0; row < 4; row++)
                    sh[row+4*c] = sub_table[st[row + 4*((c + row) % 4)]];
            if (r != ROUND_COUNT) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = sh[4*c];
                    a1 = sh[4*c+1];
                    a2 = sh[4*c+2];
                    a3 = sh[4*c+3];
                    sh[4*c]   = gf_mul(a0, 8'h02) ^ gf_mul(a1, 8'h03) ^ a2 ^ a3;
                    sh[4*c+1] = a0 ^ gf_mul(a1, 8'h02) ^ gf_mul(a2, 8'h03) ^ a3;
                    sh[4*c+2] = a0 ^ a1 ^ gf_mul(a2, 8'h02) ^ gf_mul(a3, 8'h03);
                    sh[4*c+3] = gf_mul(a0, 8'h03) ^ a1 ^ a2 ^ gf_mul(a3, 8'h02);
                end
            end
            for (int i = 0; i < 16; i++)
                st[i] = sh[i] ^ round_key[r][127-8*i -: 8];
        end
        for (int i = 0; i < 16; i++) res[127-8*i -: 8] = st[i];
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    task automatic write_key_reg(input logic [PADDR_W-1:0] addr, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_KEY_HIGH || addr == ADDR_KEY_LOW) begin
            if (addr == ADDR_KEY_HIGH) key_high_q = value;
            else key_low_q = value;
            schedule_keys();
            key_loads++;
        end
        // let the key schedule finish before anything else
        repeat (SCHEDULE_CYCLES) @(posedge i_clk);
    endtask

    task automatic read_key_reg(input logic [PADDR_W-1:0] addr, input logic [63:0] want,
                                input string what);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== want) report_mismatch(what, prdata, want);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic load_key(input logic [63:0] hi, input logic [63:0] lo);
        write_key_reg(ADDR_KEY_HIGH, hi);
        write_key_reg(ADDR_KEY_LOW, lo);
    endtask

    // tvalid stays high after a beat so back-to-back beats need no drop
    task automatic send_block(input logic [63:0] hi, input logic [63:0] lo);
        int gap;
        gap = $urandom_range(0, src_gap_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {lo, hi};
        do @(posedge i_clk); while (!s_axis_tready);
        cipher_expected.push_back(encrypt_block({hi, lo}));
        blocks_sent++;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (cipher_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [63:0] random_half();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 5))
            0: v = 64'h1 << $urandom_range(0, 63);
            1: v = ~(64'h1 << $urandom_range(0, 63));
            default: ;
        endcase
        return v;
    endfunction

    task automatic test_key_readback();
        read_key_reg(ADDR_KEY_HIGH, key_high_q, "key_high after reset");
        read_key_reg(ADDR_KEY_LOW, key_low_q, "key_low after reset");
        load_key(random_half(), random_half());
        read_key_reg(ADDR_KEY_HIGH, key_high_q, "key_high readback");
        read_key_reg(ADDR_KEY_LOW, key_low_q, "key_low readback");
        send_block(random_half(), random_half());
        drain_results();
    endtask

    task automatic test_standard_vector();
        load_key(64'h0001020304050607, 64'h08090a0b0c0d0e0f);
        send_block(64'h0011223344556677, 64'h8899aabbccddeeff);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        drain_results();
    endtask

    task automatic test_key_extremes();
        load_key('1, '1);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h8000000000000000, 64'h0000000000000001);
        send_block(64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
        drain_results();
        load_key(64'h0, 64'h0);
        send_block(64'h0, 64'h0);
        send_block('1, '1);
        send_block(64'h0000000000000001, 64'h8000000000000000);
        send_block(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa);
        drain_results();
    endtask

    // only one half of the key changes, the other keeps its value
    task automatic test_partial_key();
        write_key_reg(ADDR_KEY_LOW, random_half());
        send_block(random_half(), random_half());
        send_block(random_half(), random_half());
        drain_results();
        write_key_reg(ADDR_KEY_HIGH, random_half());
        send_block(random_half(), random_half());
        drain_results();
    endtask

    task automatic test_unmapped_write();
        write_key_reg(ADDR_HOLE_A, random_half());
        write_key_reg(ADDR_HOLE_B, random_half());
        read_key_reg(ADDR_KEY_HIGH, key_high_q, "key_high after unmapped write");
        read_key_reg(ADDR_KEY_LOW, key_low_q, "key_low after unmapped write");
        send_block(random_half(), random_half());
        send_block(random_half(), random_half());
        drain_results();
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_output_stall();
        load_key(random_half(), random_half());
        src_gap_max = 0;
        sink_hold   = STALL_CYCLES;
        if (STALL_CYCLES > longest_hold) longest_hold = STALL_CYCLES;
        repeat (30) send_block(random_half(), random_half());
        drain_results();
        src_gap_max = GAP_MAX;
    endtask

    task automatic test_random_traffic();
        int sent;
        int phase_len;
        sent = 0;
        while (sent < RANDOM_BLOCKS) begin
            case ($urandom_range(0, 5))
                0:       write_key_reg(ADDR_KEY_HIGH, random_half());
                1:       write_key_reg(ADDR_KEY_LOW, random_half());
                default: load_key(random_half(), random_half());
            endcase
            src_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            sink_gap_max = ($urandom_range(0, 3) == 0) ? 0 : GAP_MAX;
            phase_len    = $urandom_range(40, 120);
            for (int i = 0; i < phase_len; i++) begin
                send_block(random_half(), random_half());
                sent++;
                // now and then the sender waits for every result
                if ($urandom_range(0, 63) == 0) drain_results();
            end
            drain_results();
        end
        src_gap_max  = GAP_MAX;
        sink_gap_max = GAP_MAX;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (cipher_expected.size() == 0) begin
                report_mismatch("result beat with none pending", m_axis_tdata[63:0], 64'h0);
            end else begin
                cipher_want = cipher_expected.pop_front();
                if (m_axis_tdata[63:0] !== cipher_want[127:64])
                    report_mismatch("cipher_high", m_axis_tdata[63:0], cipher_want[127:64]);
                if (m_axis_tdata[127:64] !== cipher_want[63:0])
                    report_mismatch("cipher_low", m_axis_tdata[127:64], cipher_want[63:0]);
                results_checked++;
            end
        end
    end

    initial begin : sink_drive
        int wait_n;
        m_axis_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (sink_hold > 0) begin
                m_axis_tready <= 1'b0;
                while (sink_hold > 0) begin
                    @(posedge i_clk);
                    sink_hold--;
                end
            end
            wait_n = $urandom_range(0, sink_gap_max);
            if (wait_n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (wait_n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin : watchdog
        #(5_000_000);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin : test_sequence
        i_rst_n       <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        build_sub_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_key_readback();
        test_standard_vector();
        test_key_extremes();
        test_partial_key();
        test_unmapped_write();
        test_output_stall();
        test_random_traffic();

        drain_results();
        $display("encrypted %0d blocks and checked %0d results over %0d key schedules",
                 blocks_sent, results_checked, key_loads);
        $display("covered key extremes, half-key updates, unmapped writes, gaps up to %0d, and a %0d-cycle output stall",
                 GAP_MAX, longest_hold);
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/aes_pkg.sv
rtl/aes_dp.sv
rtl/aes_ctrl.sv
rtl/aes128_block_encrypt_core.sv
bench/tb.sv
